/* rtl/nrso_pkg.sv */
// Package with shared widths, register indexes and types for the resize offset core.
`timescale 1ns / 1ps
package nrso_pkg;
  localparam int unsigned NumAx = 4;
  localparam int unsigned DimW = 13;
  localparam int unsigned ScaleW = 24;
  localparam int unsigned CoordW = 12;
  localparam int unsigned OffW = 48;
  localparam int unsigned QuoW = CoordW + 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned DefAxes = 4;
  localparam int unsigned DefMaxDim = 4096;

  localparam logic [CfgIdxW-1:0] RegDim0 = 4'd0;
  localparam logic [CfgIdxW-1:0] RegDim3 = 4'd3;
  localparam logic [CfgIdxW-1:0] RegScale0 = 4'd4;
  localparam logic [CfgIdxW-1:0] RegScale3 = 4'd7;

  typedef struct packed {
    logic [QuoW-1:0] rem;
    logic [CoordW:0] quo;
  } div_lane_t;
endpackage

/* rtl/nrso_div_cell.sv */
// One restoring-division cell: one quotient bit for every axis lane, registered.
`timescale 1ns / 1ps
module nrso_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  logic [nrso_pkg::NumAx-1:0][nrso_pkg::ScaleW-1:0] scale_i,
  input  nrso_pkg::div_lane_t [nrso_pkg::NumAx-1:0] lane_i,
  output logic vld_o,
  output nrso_pkg::div_lane_t [nrso_pkg::NumAx-1:0] lane_o
);
  localparam int unsigned RW = nrso_pkg::QuoW + nrso_pkg::ScaleW + 1;
  nrso_pkg::div_lane_t [nrso_pkg::NumAx-1:0] lane_d, lane_q;
  logic vld_q;

  always_comb begin
    logic [RW-1:0] rem_w, sub_w;
    lane_d = lane_i;
    for (int a = 0; a < nrso_pkg::NumAx; a++) begin
      rem_w = RW'(lane_i[a].rem);
      sub_w = RW'(scale_i[a]) << Bit;
      if (scale_i[a] == '0) begin
        lane_d[a].quo[Bit] = 1'b1;
      end else if (rem_w >= sub_w) begin
        lane_d[a].quo[Bit] = 1'b1;
        lane_d[a].rem = nrso_pkg::QuoW'(rem_w - sub_w);
      end else begin
        lane_d[a].quo[Bit] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign vld_o = vld_q;
  assign lane_o = lane_q;
endmodule

/* rtl/nrso_offset.sv */
// Clamp and offset accumulation stages: clamp, then Horner products one axis per stage.
`timescale 1ns / 1ps
module nrso_offset #(
  parameter int unsigned Axes = nrso_pkg::DefAxes,
  parameter int unsigned MaxDim = nrso_pkg::DefMaxDim
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  logic [nrso_pkg::NumAx-1:0][nrso_pkg::DimW-1:0] dim_i,
  input  nrso_pkg::div_lane_t [nrso_pkg::NumAx-1:0] lane_i,
  output logic vld_o,
  output logic [nrso_pkg::OffW-1:0] off_o,
  output logic [nrso_pkg::NumAx-1:0][nrso_pkg::CoordW-1:0] src_o
);
  localparam int unsigned N = nrso_pkg::NumAx;
  localparam int unsigned CW = nrso_pkg::CoordW;
  localparam int unsigned SW = CW + 1;
  localparam int unsigned EW = $clog2(MaxDim + 1);

  logic [N-1:0][EW-1:0] edim;
  logic [N-1:0][SW-1:0] src_d;
  logic [N:0] vld_q;
  logic [N:0][N-1:0][SW-1:0] src_q;
  logic [N:0][nrso_pkg::OffW-1:0] acc_q;

  always_comb begin
    logic [nrso_pkg::QuoW:0] lim;
    for (int a = 0; a < N; a++) begin
      if (a + Axes < N) begin
        edim[a] = EW'(1);
      end else if (dim_i[a] == '0) begin
        edim[a] = EW'(1);
      end else if (32'(dim_i[a]) > MaxDim) begin
        edim[a] = EW'(MaxDim);
      end else begin
        edim[a] = EW'(dim_i[a]);
      end
      lim = (nrso_pkg::QuoW + 1)'(edim[a]) - 1'b1;
      if ((nrso_pkg::QuoW + 1)'(lane_i[a].quo) > lim) begin
        src_d[a] = SW'(lim);
      end else begin
        src_d[a] = SW'(lane_i[a].quo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      src_q[0] <= src_d;
      acc_q[0] <= '0;
      for (int s = 0; s < N; s++) begin
        src_q[s+1] <= src_q[s];
        acc_q[s+1] <= nrso_pkg::OffW'(acc_q[s] * edim[s]) + nrso_pkg::OffW'(src_q[s][s]);
      end
    end
  end

  always_comb begin
    for (int a = 0; a < N; a++) begin
      src_o[a] = src_q[N][a][CW-1:0];
    end
  end

  assign vld_o = vld_q[N];
  assign off_o = acc_q[N];
endmodule

/* rtl/nearest_resize_source_offset_core.sv */
// Top level of the nearest-neighbor resize source offset generator.
// Pipeline from input transaction to result: 13 divider cells, clamp, 4 offset stages.
// Throughput: one transaction per cycle; the whole chain advances when the output slot is free.
// The chain of divider cells, one quotient bit each, makes up most of the latency.
// Reset clears all valid bits and loads dims to 1 and scales to 1.0.
`timescale 1ns / 1ps
module nearest_resize_source_offset_core #(
  parameter int unsigned Axes = nrso_pkg::DefAxes,
  parameter int unsigned MaxDim = nrso_pkg::DefMaxDim
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // out_coord_0, out_coord_1, out_coord_2, out_coord_3 from bit 0 up.
  input  logic [47:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // src_offset, src_coord_0, src_coord_1, src_coord_2, src_coord_3 from bit 0 up.
  output logic [95:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [nrso_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [nrso_pkg::ScaleW-1:0] cfg_data_i
);
  localparam int unsigned N = nrso_pkg::NumAx;
  localparam int unsigned CW = nrso_pkg::CoordW;
  localparam int unsigned NB = CW + 1;

  logic [N-1:0][nrso_pkg::DimW-1:0] dim_q;
  logic [N-1:0][nrso_pkg::ScaleW-1:0] scale_q;
  logic en;
  logic [NB:0] vld_c;
  nrso_pkg::div_lane_t [NB:0][N-1:0] lane_c;
  logic ov;
  logic [nrso_pkg::OffW-1:0] off;
  logic [N-1:0][CW-1:0] src;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < N; a++) begin
        dim_q[a] <= nrso_pkg::DimW'(1);
        scale_q[a] <= nrso_pkg::ScaleW'(65536);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i <= nrso_pkg::RegDim3) begin
        dim_q[cfg_idx_i[1:0]] <= cfg_data_i[nrso_pkg::DimW-1:0];
      end else if (cfg_idx_i >= nrso_pkg::RegScale0 && cfg_idx_i <= nrso_pkg::RegScale3) begin
        scale_q[cfg_idx_i[1:0]] <= cfg_data_i;
      end
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    vld_c[NB] = s_axis_tvalid;
    for (int a = 0; a < N; a++) begin
      lane_c[NB][a].rem = {s_axis_tdata[a*CW +: CW], 16'd0};
      lane_c[NB][a].quo = '0;
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_div
    nrso_div_cell #(.Bit(b)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(vld_c[b+1]), .scale_i(scale_q), .lane_i(lane_c[b+1]),
      .vld_o(vld_c[b]), .lane_o(lane_c[b])
    );
  end

  nrso_offset #(.Axes(Axes), .MaxDim(MaxDim)) u_off (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(vld_c[0]), .dim_i(dim_q), .lane_i(lane_c[0]),
    .vld_o(ov), .off_o(off), .src_o(src)
  );

  always_comb begin
    m_axis_tvalid = ov;
    m_axis_tdata[nrso_pkg::OffW-1:0] = off;
    for (int a = 0; a < N; a++) begin
      m_axis_tdata[nrso_pkg::OffW + a*CW +: CW] = (a + Axes < N) ? '0 : src[a];
    end
  end
endmodule

/* rtl/nrso_checker.sv */
// Port-level checker for the resize offset core, bound to the top level.
`timescale 1ns / 1ps
module nrso_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [95:0] m_axis_tdata
);
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("ready low with empty output");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("input taken in stall");
endmodule

bind nearest_resize_source_offset_core nrso_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
